// File: design/swqt_pkg.sv
// swqt_pkg: shared types and codes for the semaphore wait queue table
// used by the controller, the datapath and the checker

package swqt_pkg;

    localparam int FUNC_BITS = 2;
    localparam int KEY_W     = 32;
    localparam int PID_W     = 5;
    localparam int STAT_W    = 2;

    localparam logic [FUNC_BITS-1:0] FUNC_BLOCK  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_OUTPID = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_PEEK   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFREE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic ld_in;
        logic srch;
        logic rd_desc;
        logic rd_link;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// File: design/swqt_if.sv
// swqt_if: request and response channel interfaces
// depends on swqt_pkg for field widths

interface swqt_req_if;
    import swqt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [FUNC_BITS-1:0] func;
    logic [KEY_W-1:0]     sem_key;
    logic [PID_W-1:0]     proc_id;
    modport source (output valid, func, sem_key, proc_id, input ready);
    modport sink   (input valid, func, sem_key, proc_id, output ready);
endinterface

interface swqt_rsp_if;
    import swqt_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [PID_W-1:0]  proc_out;
    logic              proc_valid;
    modport source (output valid, status, proc_out, proc_valid, input ready);
    modport sink   (input valid, status, proc_out, proc_valid, output ready);
endinterface

// File: design/swqt_ctrl.sv
// swqt_ctrl: sequencer for one request (search, descriptor read, link read, commit)
// depends on swqt_pkg

module swqt_ctrl import swqt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SRCH = 5'b00010,
        S_RDD  = 5'b00100,
        S_RDL  = 5'b01000,
        S_COMM = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                o_cmd.srch = 1'b1;
                n_state = S_RDD;
            end
            S_RDD: begin
                o_cmd.rd_desc = 1'b1;
                n_state = S_RDL;
            end
            S_RDL: begin
                o_cmd.rd_link = 1'b1;
                n_state = S_COMM;
            end
            S_COMM: begin
                // hold until the result register can take the item
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/swqt_dp.sv
// swqt_dp: descriptor pool, wait queue links and result register
// depends on swqt_pkg

module swqt_dp import swqt_pkg::*; #(
    parameter int NUM_PROCS = 20,
    parameter int KEY_BITS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [FUNC_BITS-1:0] i_func,
    input  logic [KEY_W-1:0]     i_sem_key,
    input  logic [PID_W-1:0]     i_proc_id,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic [PID_W-1:0]     o_proc_out,
    output logic                 o_proc_valid
);

    localparam int PW = $clog2(NUM_PROCS);
    localparam int KB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    // pool and link storage
    logic          r_act   [NUM_PROCS];
    logic [KB-1:0] r_key   [NUM_PROCS];
    logic [PW-1:0] r_head  [NUM_PROCS];
    logic [PW-1:0] r_tail  [NUM_PROCS];
    logic [PW-1:0] r_next  [NUM_PROCS];
    logic [PW-1:0] r_prev  [NUM_PROCS];
    logic          r_blk_v [NUM_PROCS];
    logic [PW-1:0] r_blk_d [NUM_PROCS];

    // request and per-step registers
    logic [FUNC_BITS-1:0] r_func;
    logic [KB-1:0]        r_kin;
    logic [PID_W-1:0]     r_pid;
    logic                 r_pok, r_blk, r_hit, r_free_ok;
    logic [PW-1:0]        r_d, r_hd, r_tl, r_nx, r_pv;

    logic                 r_ovalid, r_opvld;
    logic [STAT_W-1:0]    r_ostat;
    logic [PID_W-1:0]     r_opout;

    logic [PW-1:0] pidx, hit_idx, free_idx, tgt_p;
    logic          hit_any, free_any;

    assign pidx = PW'(r_pid);

    // key match and lowest free descriptor
    always_comb begin
        hit_idx  = '0;
        hit_any  = 1'b0;
        free_idx = '0;
        free_any = 1'b0;
        for (int d = NUM_PROCS - 1; d >= 0; d--) begin
            if (r_act[d] && r_key[d] == r_kin) begin
                hit_idx = PW'(d);
                hit_any = 1'b1;
            end
            if (!r_act[d]) begin
                free_idx = PW'(d);
                free_any = 1'b1;
            end
        end
    end

    // process whose links are read: head for remove/peek, named process otherwise
    assign tgt_p = (r_func == FUNC_REMOVE || r_func == FUNC_PEEK) ? r_hd : pidx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_func <= i_func;
            r_kin  <= i_sem_key[KB-1:0];
            r_pid  <= i_proc_id;
            r_pok  <= (32'(i_proc_id) < 32'(NUM_PROCS));
        end
        if (i_cmd.srch) begin
            r_blk     <= r_pok && r_blk_v[pidx];
            r_hit     <= hit_any;
            r_free_ok <= free_any;
            if (r_func == FUNC_OUTPID) begin
                r_d <= r_blk_d[pidx];
            end else if (hit_any) begin
                r_d <= hit_idx;
            end else begin
                r_d <= free_idx;
            end
        end
        if (i_cmd.rd_desc) begin
            r_hd <= r_head[r_d];
            r_tl <= r_tail[r_d];
        end
        if (i_cmd.rd_link) begin
            r_nx <= r_next[tgt_p];
            r_pv <= r_prev[tgt_p];
        end
    end

    // commit: decide result and table updates
    logic          act_we, act_wd, key_we, head_we, tail_we, next_we, prev_we;
    logic          blk_we, blk_wv;
    logic [PW-1:0] head_wd, tail_wd, next_wa, next_wd, prev_wa, prev_wd;
    logic [STAT_W-1:0] res_stat;
    logic          res_pvld, do_unlink;
    logic [PID_W-1:0] res_pout;

    always_comb begin
        act_we = 1'b0; act_wd = 1'b0; key_we = 1'b0;
        head_we = 1'b0; head_wd = tgt_p;
        tail_we = 1'b0; tail_wd = tgt_p;
        next_we = 1'b0; next_wa = r_tl; next_wd = tgt_p;
        prev_we = 1'b0; prev_wa = tgt_p; prev_wd = r_tl;
        blk_we = 1'b0; blk_wv = 1'b0;
        res_stat = ST_NOTFOUND; res_pvld = 1'b0; res_pout = '0;
        do_unlink = 1'b0;
        case (r_func)
            FUNC_BLOCK: begin
                if (r_pok && !r_blk) begin
                    if (r_hit) begin
                        // append behind the current tail
                        next_we = 1'b1;
                        prev_we = 1'b1;
                        tail_we = 1'b1;
                        blk_we = 1'b1; blk_wv = 1'b1;
                        res_stat = ST_OK;
                    end else if (r_free_ok) begin
                        act_we = 1'b1; act_wd = 1'b1; key_we = 1'b1;
                        head_we = 1'b1; tail_we = 1'b1;
                        blk_we = 1'b1; blk_wv = 1'b1;
                        res_stat = ST_OK;
                    end else begin
                        res_stat = ST_NOFREE;
                    end
                end
            end
            FUNC_REMOVE, FUNC_PEEK: begin
                if (r_hit) begin
                    res_stat = ST_OK;
                    res_pvld = 1'b1;
                    res_pout = PID_W'(r_hd);
                    do_unlink = (r_func == FUNC_REMOVE);
                end
            end
            FUNC_OUTPID: begin
                if (r_blk) begin
                    res_stat = ST_OK;
                    res_pvld = 1'b1;
                    res_pout = r_pid;
                    do_unlink = 1'b1;
                end
            end
            default: res_stat = ST_NOTFOUND;
        endcase
        if (do_unlink) begin
            blk_we = 1'b1; blk_wv = 1'b0;
            if (r_hd == tgt_p) begin
                if (r_tl == tgt_p) begin
                    act_we = 1'b1; act_wd = 1'b0;
                end else begin
                    head_we = 1'b1; head_wd = r_nx;
                end
            end else begin
                next_we = 1'b1; next_wa = r_pv; next_wd = r_nx;
                if (r_tl == tgt_p) begin
                    tail_we = 1'b1; tail_wd = r_pv;
                end else begin
                    prev_we = 1'b1; prev_wa = r_nx; prev_wd = r_pv;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_PROCS; d++) begin
                r_act[d]   <= 1'b0;
                r_blk_v[d] <= 1'b0;
            end
        end else if (i_cmd.commit) begin
            if (act_we) r_act[r_d] <= act_wd;
            if (blk_we) r_blk_v[tgt_p] <= blk_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (key_we)  r_key[r_d]       <= r_kin;
            if (head_we) r_head[r_d]      <= head_wd;
            if (tail_we) r_tail[r_d]      <= tail_wd;
            if (next_we) r_next[next_wa]  <= next_wd;
            if (prev_we) r_prev[prev_wa]  <= prev_wd;
            if (blk_we)  r_blk_d[tgt_p]   <= r_d;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ostat <= res_stat;
            r_opout <= res_pout;
            r_opvld <= res_pvld;
        end
    end

    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid  = r_ovalid;
    assign o_status     = r_ostat;
    assign o_proc_out   = r_opout;
    assign o_proc_valid = r_opvld;

endmodule

// File: design/semaphore_wait_queue_table_core.sv
// semaphore_wait_queue_table_core: top level of the semaphore wait queue table
// depends on swqt_pkg, swqt_if, swqt_ctrl and swqt_dp
//
// Usage: requests enter on i_req (func, sem_key, proc_id) with valid/ready;
// an item is taken at a clock edge where both are high. Each request gives
// exactly one response on o_rsp (status, proc_out, proc_valid).
// func 0 blocks proc_id on sem_key, 1 pops the first waiter, 2 removes
// proc_id from whatever queue holds it, 3 peeks at the head of sem_key.
// The response is registered after the search, descriptor read, link read
// and commit steps. A new request is taken only after commit, as set by the
// dependent table reads (key search, descriptor head/tail, queue links).
// The response sits in an output register, so a new request is taken while
// the last response still waits; if the receiver stalls, the next request
// holds in its commit step until the output register frees up.
// Reset (i_rst_n low, synchronous) frees all descriptors and marks every
// process as not blocked; no clearing pass is needed.

module semaphore_wait_queue_table_core import swqt_pkg::*; #(
    parameter int NUM_PROCS = 20,
    parameter int KEY_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swqt_req_if.sink    i_req,
    swqt_rsp_if.source  o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    swqt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    swqt_dp #(
        .NUM_PROCS (NUM_PROCS),
        .KEY_BITS  (KEY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_req.func),
        .i_sem_key    (i_req.sem_key),
        .i_proc_id    (i_req.proc_id),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_status     (o_rsp.status),
        .o_proc_out   (o_rsp.proc_out),
        .o_proc_valid (o_rsp.proc_valid)
    );

endmodule

// File: design/swqt_chk.sv
// swqt_chk: port-level checks for the semaphore wait queue table
// depends on swqt_pkg; bound to semaphore_wait_queue_table_core

module swqt_chk import swqt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [STAT_W-1:0] i_status,
    input logic [PID_W-1:0]  i_proc_out,
    input logic              i_proc_valid
);

    // a returned process only comes with an ok status
    a_pvld_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_proc_valid |-> i_status == ST_OK)
        else $error("process returned with failing status");

    // no process means a zero process field
    a_pout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_proc_valid |-> i_proc_out == '0)
        else $error("proc_out not zero without proc_valid");

    // nothing is offered right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    // one request at a time: no new item the cycle after one is taken
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    // a stalled response item holds its value
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_proc_out) && $stable(i_proc_valid))
        else $error("response changed while stalled");

endmodule

bind semaphore_wait_queue_table_core swqt_chk u_swqt_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_proc_out   (o_rsp.proc_out),
    .i_proc_valid (o_rsp.proc_valid)
);
